@@ hw/rtl/sibd_pkg.sv @@
// Shared types and constants for the signed integer to base digits unit.
package sibd_pkg;

  // Fixed field widths
  localparam int unsigned NumW    = 32;
  localparam int unsigned CharW   = 8;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned LenW    = 5;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned TabW    = 2 * CfgW;

  // Long division: magnitude bits consumed per cycle and division steps per digit
  localparam int unsigned DivBits   = 8;
  localparam int unsigned DivCycles = NumW / DivBits;
  localparam int unsigned StepW     = $clog2(DivCycles);

  // Special symbols and the printable range
  localparam logic [CharW-1:0] SymPlus  = 8'h2B;
  localparam logic [CharW-1:0] SymMinus = 8'h2D;
  localparam logic [CharW-1:0] SymMin   = 8'd32;
  localparam logic [CharW-1:0] SymMax   = 8'd126;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegSymbolsLow  = 2'd0,
    RegSymbolsHigh = 2'd1,
    RegBaseLen     = 2'd2
  } reg_idx_e;

  // Controller states
  typedef enum logic [1:0] {
    StIdle,
    StSign,
    StDiv,
    StEmit
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // latch a new item
    logic emit_sign;  // present the minus sign
    logic sign_last;  // minus sign ends the item
    logic div_step;   // run one division step
    logic div_last;   // final step of a digit: store it
    logic emit_digit; // read out the next stored digit
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic neg;        // item is negative
    logic base_ok;    // symbol table forms a valid base
    logic div_done;   // all digits stored
    logic cnt_one;    // one stored digit left
    logic pending;    // a digit read is still in flight
  } dp_status_t;

endpackage

@@ hw/rtl/sibd_datapath.sv @@
// Datapath: config registers, base check, digit divider, digit store, output register.
module sibd_datapath #(
  parameter int unsigned MAX_BASE    = 16,
  parameter int unsigned DIGIT_SLOTS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sibd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [sibd_pkg::CfgW-1:0]         cfg_data_i,
  input  logic signed [sibd_pkg::NumW-1:0]  number_i,
  input  sibd_pkg::dp_cmd_t                 cmd_i,
  output sibd_pkg::dp_status_t              status_o,
  output logic                              strobe_o,
  output logic [sibd_pkg::CharW-1:0]        character_o,
  output logic                              last_o
);

  localparam int unsigned CntW  = $clog2(DIGIT_SLOTS + 1);
  localparam int unsigned AddrW = $clog2(DIGIT_SLOTS);

  // Check a symbol table: count in range, symbols printable, no sign, no repeats
  function automatic logic base_check(logic [sibd_pkg::TabW-1:0] tab,
                                      logic [sibd_pkg::LenW-1:0] len);
    logic                       ok;
    logic [sibd_pkg::CharW-1:0] s;
    ok = (len >= sibd_pkg::LenW'(2)) && (len <= sibd_pkg::LenW'(MAX_BASE));
    for (int i = 0; i < 16; i++) begin
      s = tab[8*i +: 8];
      if (sibd_pkg::LenW'(i) < len) begin
        if (s == sibd_pkg::SymPlus || s == sibd_pkg::SymMinus ||
            !(s inside {[sibd_pkg::SymMin:sibd_pkg::SymMax]})) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < 16; j++) begin
          if (sibd_pkg::LenW'(j) < len && tab[8*j +: 8] == s) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

  logic [sibd_pkg::CfgW-1:0]   sym_low_q, sym_high_q;
  logic [sibd_pkg::LenW-1:0]   base_len_q;
  logic [sibd_pkg::TabW-1:0]   tab;
  logic                        base_ok_q;
  logic [sibd_pkg::NumW-1:0]   mag_q, mag_d, raw;
  logic                        neg_q;
  logic [sibd_pkg::DigitW-1:0] rem_q, rem_d, rem_v;
  logic [sibd_pkg::DivBits-1:0] qbits;
  logic [sibd_pkg::LenW-1:0]   trial;
  logic [CntW-1:0]             cnt_q, cnt_d, cnt_dec;
  logic [sibd_pkg::DigitW-1:0] dig_mem [DIGIT_SLOTS];
  logic [sibd_pkg::DigitW-1:0] rd_q;
  logic                        rd_valid_q, rd_last_q;
  logic                        out_strobe_q, out_last_q;
  logic [sibd_pkg::CharW-1:0]  out_char_q;

  assign tab     = {sym_high_q, sym_low_q};
  assign raw     = number_i;
  assign cnt_dec = cnt_q - CntW'(1);

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_low_q  <= '0;
      sym_high_q <= '0;
      base_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sibd_pkg::RegSymbolsLow:  sym_low_q  <= cfg_data_i;
        sibd_pkg::RegSymbolsHigh: sym_high_q <= cfg_data_i;
        sibd_pkg::RegBaseLen:     base_len_q <= cfg_data_i[sibd_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // Register the base check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_ok_q <= 1'b0;
    end else begin
      base_ok_q <= base_check(tab, base_len_q);
    end
  end

  // Divide by the radix, one magnitude bit per restoring step
  always_comb begin
    rem_v = rem_q;
    qbits = '0;
    trial = '0;
    for (int k = 0; k < sibd_pkg::DivBits; k++) begin
      trial = {1'b0, rem_v} << 1;
      trial[0] = mag_q[sibd_pkg::NumW-1-k];
      if (trial >= base_len_q) begin
        qbits[sibd_pkg::DivBits-1-k] = 1'b1;
        rem_v = sibd_pkg::DigitW'(trial - base_len_q);
      end else begin
        rem_v = trial[sibd_pkg::DigitW-1:0];
      end
    end
  end

  // Next values of magnitude, remainder and digit count
  always_comb begin
    mag_d = mag_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      mag_d = raw[sibd_pkg::NumW-1] ? (sibd_pkg::NumW'(0) - raw) : raw;
      rem_d = '0;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      mag_d = {mag_q[sibd_pkg::NumW-sibd_pkg::DivBits-1:0], qbits};
      rem_d = cmd_i.div_last ? '0 : rem_v;
      if (cmd_i.div_last) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end else if (cmd_i.emit_digit) begin
      cnt_d = cnt_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    if (cmd_i.load) begin
      neg_q <= raw[sibd_pkg::NumW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Digit store, least significant digit first
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && cmd_i.div_last) begin
      dig_mem[cnt_q[AddrW-1:0]] <= rem_v;
    end
    if (cmd_i.emit_digit) begin
      rd_q <= dig_mem[cnt_dec[AddrW-1:0]];
    end
  end

  // Track the digit read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      rd_last_q  <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.emit_digit;
      rd_last_q  <= (cnt_q == CntW'(1));
    end
  end

  // Output register: minus sign or looked-up digit symbol
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_strobe_q <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      out_strobe_q <= cmd_i.emit_sign | rd_valid_q;
      out_last_q   <= cmd_i.emit_sign ? cmd_i.sign_last : rd_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      out_char_q <= sibd_pkg::SymMinus;
    end else if (rd_valid_q) begin
      out_char_q <= tab[8*rd_q +: 8];
    end
  end

  assign strobe_o    = out_strobe_q;
  assign character_o = out_char_q;
  assign last_o      = out_last_q;

  // Status back to the controller
  assign status_o.neg      = neg_q;
  assign status_o.base_ok  = base_ok_q;
  assign status_o.div_done = (cnt_q != '0) &&
                             ((mag_q == '0) || (cnt_q == CntW'(DIGIT_SLOTS)));
  assign status_o.cnt_one  = (cnt_q == CntW'(1));
  assign status_o.pending  = rd_valid_q;

endmodule

@@ hw/rtl/sibd_ctrl.sv @@
// Controller: sequences sign, division steps and digit readout for each item.
module sibd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  sibd_pkg::dp_status_t status_i,
  output sibd_pkg::dp_cmd_t    cmd_o
);

  sibd_pkg::state_e         state_q, state_d;
  logic [sibd_pkg::StepW-1:0] step_q, step_d;
  logic                     accept;

  assign busy   = (state_q != sibd_pkg::StIdle) | status_i.pending;
  assign accept = start & ~busy;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sibd_pkg::StIdle: begin
        if (accept) state_d = sibd_pkg::StSign;
      end
      sibd_pkg::StSign: begin
        state_d = status_i.base_ok ? sibd_pkg::StDiv : sibd_pkg::StIdle;
      end
      sibd_pkg::StDiv: begin
        if (step_q == '0 && status_i.div_done) state_d = sibd_pkg::StEmit;
      end
      sibd_pkg::StEmit: begin
        if (status_i.cnt_one) state_d = sibd_pkg::StIdle;
      end
      default: state_d = sibd_pkg::StIdle;
    endcase
  end

  // Datapath commands and step count
  always_comb begin
    cmd_o  = '0;
    step_d = '0;
    case (state_q)
      sibd_pkg::StIdle: begin
        cmd_o.load = accept;
      end
      sibd_pkg::StSign: begin
        cmd_o.emit_sign = status_i.neg;
        cmd_o.sign_last = ~status_i.base_ok;
      end
      sibd_pkg::StDiv: begin
        if (!(step_q == '0 && status_i.div_done)) begin
          cmd_o.div_step = 1'b1;
          cmd_o.div_last = (step_q == sibd_pkg::StepW'(sibd_pkg::DivCycles - 1));
          step_d         = step_q + sibd_pkg::StepW'(1);
        end
      end
      sibd_pkg::StEmit: begin
        cmd_o.emit_digit = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sibd_pkg::StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

@@ hw/rtl/signed_int_to_base_digits_unit.sv @@
// The minus sign follows accept through the sign state and the output register. Digits are made
// by the radix divider, 8 bits a cycle, and are then shown one a cycle.
// A new item is accepted only once the last digit read of the previous one is done; busy shows this.
// An invalid base ends the item in the sign state (sign only, or no result).
// Reset is asynchronous, active low; it clears the config and control registers and returns the unit to idle.
// Results are shown for one cycle under strobe_o; the receiver cannot stall them.
module signed_int_to_base_digits_unit #(
  parameter int unsigned MAX_BASE    = 16,
  parameter int unsigned DIGIT_SLOTS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sibd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [sibd_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [sibd_pkg::NumW-1:0]  number_i,
  output logic                              strobe_o,
  output logic [sibd_pkg::CharW-1:0]        character_o,
  output logic                              last_o
);

  sibd_pkg::dp_cmd_t    cmd;
  sibd_pkg::dp_status_t status;

  sibd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  sibd_datapath #(
    .MAX_BASE    (MAX_BASE),
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .number_i    (number_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the signed integer to base digits unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxBase    = 16;
  localparam int unsigned DigitSlots = 32;
  localparam int unsigned IdleHold   = 8;
  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned PhaseItems = 12;
  localparam int unsigned RandPhases = 6;

  // Index with no register behind it: writes there must change nothing
  localparam logic [sibd_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  localparam logic [sibd_pkg::NumW-1:0] IntMin = 32'h8000_0000;
  localparam logic [sibd_pkg::NumW-1:0] IntMax = 32'h7FFF_FFFF;
  localparam logic [sibd_pkg::NumW-1:0] NegOne = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [sibd_pkg::CharW-1:0] ch;
    logic                       last;
  } glyph_t;

  // Predicts the character stream of each number and checks it on arrival
  class text_scoreboard;
    logic [sibd_pkg::CfgW-1:0] sym_lo;
    logic [sibd_pkg::CfgW-1:0] sym_hi;
    logic [sibd_pkg::LenW-1:0] radix_len;
    glyph_t                    due_chars[$];
    int                        errors;

    function new();
      sym_lo    = '0;
      sym_hi    = '0;
      radix_len = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic [sibd_pkg::CfgIdxW-1:0] idx, logic [sibd_pkg::CfgW-1:0] data);
      case (idx)
        sibd_pkg::RegSymbolsLow:  sym_lo = data;
        sibd_pkg::RegSymbolsHigh: sym_hi = data;
        sibd_pkg::RegBaseLen:     radix_len = data[sibd_pkg::LenW-1:0];
        default: ;
      endcase
    endfunction

    function logic [sibd_pkg::CharW-1:0] symbol(int unsigned i);
      if (i < 8) return sym_lo[8*i +: 8];
      return sym_hi[8*(i-8) +: 8];
    endfunction

    function bit base_ok();
      int unsigned                n;
      logic [sibd_pkg::CharW-1:0] s;
      n = 32'(radix_len);
      if (n < 2 || n > MaxBase) return 0;
      for (int unsigned i = 0; i < n; i++) begin
        s = symbol(i);
        if (s == sibd_pkg::SymPlus || s == sibd_pkg::SymMinus ||
            s < sibd_pkg::SymMin || s > sibd_pkg::SymMax) return 0;
        for (int unsigned j = i + 1; j < n; j++)
          if (symbol(j) == s) return 0;
      end
      return 1;
    endfunction

    // Queue the characters that an accepted number must produce
    function void add_number(logic [sibd_pkg::NumW-1:0] num);
      logic                      neg;
      logic [sibd_pkg::NumW-1:0] mag;
      int unsigned               digs[DigitSlots];
      int unsigned               nd;
      int unsigned               radix;
      neg = num[sibd_pkg::NumW-1];
      mag = neg ? (32'd0 - num) : num;
      nd  = 0;
      if (!base_ok()) begin
        if (neg) due_chars.push_back('{sibd_pkg::SymMinus, 1'b1});
        return;
      end
      if (neg) due_chars.push_back('{sibd_pkg::SymMinus, 1'b0});
      radix = 32'(radix_len);
      do begin
        digs[nd] = mag % radix;
        nd++;
        mag = mag / radix;
      end while (mag != 0 && nd < DigitSlots);
      while (nd > 0) begin
        nd--;
        due_chars.push_back('{symbol(digs[nd]), nd == 0});
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one emitted character with the oldest one due
    task check_char(logic [sibd_pkg::CharW-1:0] ch, logic lst);
      glyph_t want;
      if (due_chars.size() == 0) begin
        report($sformatf("char %02h last %0b with nothing due", ch, lst));
        return;
      end
      want = due_chars.pop_front();
      if (ch !== want.ch)
        report($sformatf("char %02h, want %02h", ch, want.ch));
      if (lst !== want.last)
        report($sformatf("last %0b, want %0b (char %02h)", lst, want.last, want.ch));
    endtask

    function int pending();
      return due_chars.size();
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [sibd_pkg::CfgIdxW-1:0]       cfg_index_i;
  logic [sibd_pkg::CfgW-1:0]          cfg_data_i;
  logic                               start;
  logic                               busy;
  logic signed [sibd_pkg::NumW-1:0]   number_i;
  logic                               strobe_o;
  logic [sibd_pkg::CharW-1:0]         character_o;
  logic                               last_o;

  text_scoreboard sb = new();
  bit             no_gaps;

  signed_int_to_base_digits_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start       (start),
    .busy        (busy),
    .number_i    (number_i),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Check every character in the cycle it is shown
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) sb.check_char(character_o, last_o);
  end

  // End the run if neither side moves anything for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || strobe_o || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Lay out a symbol string with character i in byte i
  function automatic logic [sibd_pkg::TabW-1:0] pack_syms(string s);
    logic [sibd_pkg::TabW-1:0] tab;
    tab = '0;
    for (int i = 0; i < s.len() && i < MaxBase; i++) tab[8*i +: 8] = s[i];
    return tab;
  endfunction

  // Fill the first n slots with distinct legal symbols, the rest with noise
  task automatic make_table(input int unsigned n, output logic [sibd_pkg::TabW-1:0] tab);
    bit                         used[256];
    logic [sibd_pkg::CharW-1:0] s;
    tab = {$urandom, $urandom, $urandom, $urandom};
    for (int unsigned k = 0; k < n; k++) begin
      do s = 8'($urandom_range(32, 126));
      while (used[s] || s == sibd_pkg::SymPlus || s == sibd_pkg::SymMinus);
      used[s] = 1'b1;
      tab[8*k +: 8] = s;
    end
  endtask

  // Leave the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [sibd_pkg::CfgIdxW-1:0] idx, logic [sibd_pkg::CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // Hold off new items until every due character is out and the unit is quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (IdleHold) @(posedge clk_i);
  endtask

  // Reprogram the base while idle, with a stray write to the unused index
  task automatic load_base(logic [sibd_pkg::TabW-1:0] tab, logic [sibd_pkg::CfgW-1:0] len_word);
    settle();
    write_reg(sibd_pkg::RegSymbolsLow, tab[sibd_pkg::CfgW-1:0]);
    write_reg(RegUnused, {$urandom, $urandom});
    write_reg(sibd_pkg::RegSymbolsHigh, tab[sibd_pkg::TabW-1:sibd_pkg::CfgW]);
    write_reg(sibd_pkg::RegBaseLen, len_word);
    cfg_we_i <= 1'b0;
  endtask

  // Drop start for a random while, now and then until everything has drained
  task automatic idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return;
    start <= 1'b0;
    if (r < 85) begin
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end else if (r < 95) begin
      repeat ($urandom_range(10, 60)) @(posedge clk_i);
    end else begin
      @(posedge clk_i);
      while (sb.pending() != 0) @(posedge clk_i);
    end
  endtask

  // Offer one number and hold it until the unit takes it
  task automatic send_number(logic [sibd_pkg::NumW-1:0] n);
    idle_gap();
    start    <= 1'b1;
    number_i <= n;
    do @(posedge clk_i); while (busy);
    sb.add_number(n);
  endtask

  function automatic logic [sibd_pkg::NumW-1:0] rand_number();
    logic [sibd_pkg::NumW-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 40);
      2: begin
        case ($urandom_range(0, 4))
          0: v = IntMin;
          1: v = IntMax;
          2: v = NegOne;
          3: v = IntMin + 1;
          default: v = '0;
        endcase
        return v;
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1)) v = 32'd0 - v;
    return v;
  endfunction

  initial begin
    logic [sibd_pkg::TabW-1:0] tab;
    int unsigned               n;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= sibd_pkg::RegSymbolsLow;
    cfg_data_i  <= '0;
    start       <= 1'b0;
    number_i    <= '0;
    no_gaps     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table after reset: only the sign of negatives comes out
    send_number('0);
    send_number(NegOne);
    send_number(IntMin);

    // Decimal
    load_base(pack_syms("0123456789"), 64'd10);
    send_number('0);
    send_number(32'd9);
    send_number(32'd10);
    send_number(NegOne);
    send_number(IntMax);
    send_number(IntMin);
    send_number(32'd1234567);

    // Binary: most negative number gives the longest run
    load_base(pack_syms("01"), 64'd2);
    send_number(IntMin);
    send_number(NegOne);
    send_number(32'd1);

    // Sixteen symbols, including both ends of the printable range
    load_base(pack_syms(" ~0123456789ABCD"), 64'd16);
    send_number(IntMax);
    send_number(32'hFEDC_BA99);

    // A single symbol is no base
    load_base(pack_syms("0"), 64'd1);
    send_number(-32'sd5);
    send_number(32'd5);

    // Count above the maximum
    load_base(pack_syms("0123456789ABCDEF"), 64'd17);
    send_number(-32'sd7);
    send_number(32'd7);

    // Repeated symbol, plus, minus, and symbols just outside the printable range
    load_base(pack_syms("aba"), 64'd3);
    send_number(-32'sd3);
    load_base(pack_syms("0+2"), 64'd3);
    send_number(-32'sd4);
    load_base(pack_syms("0-2"), 64'd3);
    send_number(32'd4);
    load_base(pack_syms("0\0372"), 64'd3);
    send_number(-32'sd6);
    load_base(pack_syms("01\177"), 64'd3);
    send_number(32'd6);

    // Slots past the count are never checked
    load_base(pack_syms("0123456789abcde\377"), 64'd15);
    send_number(-32'sd255);

    // Only the low five bits of the count register hold
    load_base(pack_syms("abc"), 64'hFFFF_FFFF_FFFF_FFE3);
    send_number(32'd8);

    // Random bases, mostly legal, with random numbers
    for (int p = 0; p < RandPhases; p++) begin
      if ($urandom_range(0, 3) == 0) begin
        load_base({$urandom, $urandom, $urandom, $urandom}, {$urandom, $urandom});
      end else begin
        case ($urandom_range(0, 3))
          0: n = 2;
          1: n = MaxBase;
          default: n = $urandom_range(2, MaxBase);
        endcase
        make_table(n, tab);
        load_base(tab, {$urandom, $urandom & 32'hFFFF_FFE0 | n});
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (PhaseItems) send_number(rand_number());
      no_gaps = 1'b0;
    end

    settle();
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/sibd_pkg.sv
hw/rtl/sibd_datapath.sv
hw/rtl/sibd_ctrl.sv
hw/rtl/signed_int_to_base_digits_unit.sv
bench/tb.sv
